[rtl/u8esc_pkg.sv]
`timescale 1ns / 1ps
package u8esc_pkg;

  // queue depth between front and back
  localparam int QueueDepth = 2;

  // byte codes
  localparam logic [7:0] BYTE_QUOTE     = 8'h22;
  localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
  localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;
  localparam logic [7:0] BYTE_RETURN    = 8'h0D;
  localparam logic [7:0] BYTE_TAB       = 8'h09;
  localparam logic [7:0] BYTE_DEL       = 8'h7F;
  localparam logic [7:0] BYTE_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_N         = 8'h6E;
  localparam logic [7:0] CHAR_R         = 8'h72;
  localparam logic [7:0] CHAR_T         = 8'h74;
  localparam logic [7:0] CHAR_U         = 8'h75;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;

  // lead ranges and second-byte limits
  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD4_HI  = 8'hF4;
  localparam logic [7:0] LEAD_SURR = 8'hED;
  localparam logic [7:0] LIM_A0    = 8'hA0;
  localparam logic [7:0] LIM_90    = 8'h90;

  // replacement character EF BF BD
  localparam logic [7:0] REPL_0 = 8'hEF;
  localparam logic [7:0] REPL_1 = 8'hBF;
  localparam logic [7:0] REPL_2 = 8'hBD;

  // one unit of work for the back end: replacements, body bytes, replacements
  typedef struct packed {
    logic            last;
    logic [1:0]      pre;
    logic [2:0]      len;
    logic [5:0][7:0] bytes;
    logic [1:0]      post;
  } u8esc_job_t;

  // emit phase of the back end
  typedef enum logic [1:0] {
    PH_START,
    PH_PRE,
    PH_BODY,
    PH_POST
  } u8esc_phase_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CHAR_ZERO + {4'd0, nib};
    end else begin
      r = 8'h57 + {4'd0, nib};
    end
    return r;
  endfunction

  function automatic logic [7:0] repl_byte(input logic [1:0] sel);
    logic [7:0] r;
    case (sel)
      2'd0:    r = REPL_0;
      2'd1:    r = REPL_1;
      default: r = REPL_2;
    endcase
    return r;
  endfunction

endpackage

[rtl/u8esc_front.sv]
`timescale 1ns / 1ps
module u8esc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            in_byte,
  input  logic                  end_of_string,
  output u8esc_pkg::u8esc_job_t job,
  output logic                  job_valid
);

  logic [2:0][7:0] held_bytes;
  logic [2:0][7:0] held_bytes_next;
  logic [1:0]      held_count;
  logic [1:0]      held_count_next;
  logic [1:0]      needed_count;
  logic [1:0]      needed_count_next;

  logic ok;
  logic do_fresh;

  // continuation check, including range rules on the second byte
  always_comb begin
    ok = (in_byte[7:6] == 2'b10);
    if (held_count == 2'd1) begin
      if (held_bytes[0] == u8esc_pkg::LEAD3_LO  && in_byte <  u8esc_pkg::LIM_A0) ok = 1'b0;
      if (held_bytes[0] == u8esc_pkg::LEAD_SURR && in_byte >= u8esc_pkg::LIM_A0) ok = 1'b0;
      if (held_bytes[0] == u8esc_pkg::LEAD4_LO  && in_byte <  u8esc_pkg::LIM_90) ok = 1'b0;
      if (held_bytes[0] == u8esc_pkg::LEAD4_HI  && in_byte >= u8esc_pkg::LIM_90) ok = 1'b0;
    end
  end

  // classify the item into a job and the next held state
  always_comb begin
    job               = '0;
    held_bytes_next   = held_bytes;
    held_count_next   = held_count;
    needed_count_next = needed_count;
    do_fresh          = 1'b1;

    if (held_count != 2'd0) begin
      if (ok) begin
        do_fresh = 1'b0;
        if (held_count >= needed_count) begin
          // sequence complete, pass it through
          job.len = 3'(held_count) + 3'd1;
          for (int i = 0; i < 3; i++) begin
            job.bytes[i] = held_bytes[i];
          end
          job.bytes[3'(held_count)] = in_byte;
          held_count_next   = 2'd0;
          needed_count_next = 2'd0;
        end else begin
          held_bytes_next[held_count] = in_byte;
          held_count_next             = held_count + 2'd1;
        end
      end else begin
        // broken sequence: one replacement per held byte
        job.pre           = held_count;
        held_count_next   = 2'd0;
        needed_count_next = 2'd0;
      end
    end

    if (do_fresh) begin
      if (in_byte[7]) begin
        if (in_byte >= u8esc_pkg::LEAD2_LO && in_byte <= u8esc_pkg::LEAD2_HI) begin
          held_bytes_next[0] = in_byte;
          held_count_next    = 2'd1;
          needed_count_next  = 2'd1;
        end else if (in_byte >= u8esc_pkg::LEAD3_LO && in_byte <= u8esc_pkg::LEAD3_HI) begin
          held_bytes_next[0] = in_byte;
          held_count_next    = 2'd1;
          needed_count_next  = 2'd2;
        end else if (in_byte >= u8esc_pkg::LEAD4_LO && in_byte <= u8esc_pkg::LEAD4_HI) begin
          held_bytes_next[0] = in_byte;
          held_count_next    = 2'd1;
          needed_count_next  = 2'd3;
        end else begin
          job.len      = 3'd3;
          job.bytes[0] = u8esc_pkg::REPL_0;
          job.bytes[1] = u8esc_pkg::REPL_1;
          job.bytes[2] = u8esc_pkg::REPL_2;
        end
      end else if (in_byte == u8esc_pkg::BYTE_QUOTE || in_byte == u8esc_pkg::BYTE_BACKSLASH) begin
        job.len      = 3'd2;
        job.bytes[0] = u8esc_pkg::BYTE_BACKSLASH;
        job.bytes[1] = in_byte;
      end else if (in_byte == u8esc_pkg::BYTE_NEWLINE) begin
        job.len      = 3'd2;
        job.bytes[0] = u8esc_pkg::BYTE_BACKSLASH;
        job.bytes[1] = u8esc_pkg::CHAR_N;
      end else if (in_byte == u8esc_pkg::BYTE_RETURN) begin
        job.len      = 3'd2;
        job.bytes[0] = u8esc_pkg::BYTE_BACKSLASH;
        job.bytes[1] = u8esc_pkg::CHAR_R;
      end else if (in_byte == u8esc_pkg::BYTE_TAB) begin
        job.len      = 3'd2;
        job.bytes[0] = u8esc_pkg::BYTE_BACKSLASH;
        job.bytes[1] = u8esc_pkg::CHAR_T;
      end else if (in_byte < u8esc_pkg::BYTE_SPACE || in_byte == u8esc_pkg::BYTE_DEL) begin
        job.len      = 3'd6;
        job.bytes[0] = u8esc_pkg::BYTE_BACKSLASH;
        job.bytes[1] = u8esc_pkg::CHAR_U;
        job.bytes[2] = u8esc_pkg::CHAR_ZERO;
        job.bytes[3] = u8esc_pkg::CHAR_ZERO;
        job.bytes[4] = u8esc_pkg::hex_digit(in_byte[7:4]);
        job.bytes[5] = u8esc_pkg::hex_digit(in_byte[3:0]);
      end else begin
        job.len      = 3'd1;
        job.bytes[0] = in_byte;
      end
    end

    // end of string flushes an open sequence
    if (end_of_string && held_count_next != 2'd0) begin
      job.post          = held_count_next;
      held_count_next   = 2'd0;
      needed_count_next = 2'd0;
    end

    job.last  = end_of_string;
    job_valid = accept && (job.pre != 2'd0 || job.len != 3'd0 || job.post != 2'd0);
  end

  // held state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= 2'd0;
      needed_count <= 2'd0;
    end else if (accept) begin
      held_count   <= held_count_next;
      needed_count <= needed_count_next;
    end
  end

  // held bytes, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      held_bytes <= held_bytes_next;
    end
  end

endmodule

[rtl/u8esc_fifo.sv]
`timescale 1ns / 1ps
module u8esc_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  u8esc_pkg::u8esc_job_t wr_data,
  input  logic                  rd_en,
  output u8esc_pkg::u8esc_job_t rd_data,
  output logic                  not_empty,
  output logic                  full
);

  localparam int PtrW = $clog2(u8esc_pkg::QueueDepth);

  u8esc_pkg::u8esc_job_t entries [u8esc_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;

  assign rd_data   = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == (PtrW+1)'(u8esc_pkg::QueueDepth));

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(u8esc_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(u8esc_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

[rtl/u8esc_back.sv]
`timescale 1ns / 1ps
module u8esc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  u8esc_pkg::u8esc_job_t job,
  input  logic                  job_valid,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  last_of_run,
  output logic                  string_done
);

  u8esc_pkg::u8esc_phase_t phase;
  u8esc_pkg::u8esc_phase_t phase_next;
  u8esc_pkg::u8esc_phase_t eff_phase;
  logic [1:0] rep;
  logic [1:0] rep_next;
  logic [1:0] sub;
  logic [1:0] sub_next;
  logic [2:0] idx;
  logic [2:0] idx_next;

  logic       adv;
  logic       fin;
  logic [7:0] cur_byte;

  assign adv = job_valid && (!out_valid || out_ready);
  assign pop = adv && fin;

  // pick the byte at the current position and step to the next one
  always_comb begin
    if (phase == u8esc_pkg::PH_START) begin
      if (job.pre != 2'd0) begin
        eff_phase = u8esc_pkg::PH_PRE;
      end else if (job.len != 3'd0) begin
        eff_phase = u8esc_pkg::PH_BODY;
      end else begin
        eff_phase = u8esc_pkg::PH_POST;
      end
    end else begin
      eff_phase = phase;
    end

    phase_next = eff_phase;
    rep_next   = rep;
    sub_next   = sub;
    idx_next   = idx;
    fin        = 1'b0;
    cur_byte   = u8esc_pkg::repl_byte(sub);

    unique case (eff_phase)
      u8esc_pkg::PH_BODY: begin
        cur_byte = job.bytes[idx];
        if (idx + 3'd1 == job.len) begin
          idx_next = 3'd0;
          if (job.post != 2'd0) begin
            phase_next = u8esc_pkg::PH_POST;
          end else begin
            fin = 1'b1;
          end
        end else begin
          idx_next = idx + 3'd1;
        end
      end
      u8esc_pkg::PH_PRE: begin
        if (sub == 2'd2) begin
          sub_next = 2'd0;
          rep_next = rep + 2'd1;
          if (rep + 2'd1 == job.pre) begin
            rep_next = 2'd0;
            if (job.len != 3'd0) begin
              phase_next = u8esc_pkg::PH_BODY;
            end else if (job.post != 2'd0) begin
              phase_next = u8esc_pkg::PH_POST;
            end else begin
              fin = 1'b1;
            end
          end
        end else begin
          sub_next = sub + 2'd1;
        end
      end
      u8esc_pkg::PH_POST: begin
        if (sub == 2'd2) begin
          sub_next = 2'd0;
          rep_next = rep + 2'd1;
          if (rep + 2'd1 == job.post) begin
            rep_next = 2'd0;
            fin      = 1'b1;
          end
        end else begin
          sub_next = sub + 2'd1;
        end
      end
      default: begin
        fin = 1'b1;
      end
    endcase

    if (fin) begin
      phase_next = u8esc_pkg::PH_START;
      rep_next   = 2'd0;
      sub_next   = 2'd0;
      idx_next   = 3'd0;
    end
  end

  // position within the current job
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= u8esc_pkg::PH_START;
      rep   <= 2'd0;
      sub   <= 2'd0;
      idx   <= 3'd0;
    end else if (adv) begin
      phase <= phase_next;
      rep   <= rep_next;
      sub   <= sub_next;
      idx   <= idx_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte    <= cur_byte;
      last_of_run <= fin;
      string_done <= fin && job.last;
    end
  end

endmodule

[rtl/utf8_validate_string_escape.sv]
`timescale 1ns / 1ps
// UTF-8 validator and string escaper. Raw bytes enter on the s_ side, one item
// per cycle, with tlast on the final byte of a string; escaped, validated bytes
// leave on the m_ side, tuser marking the last byte caused by an input item and
// tlast the last byte of the string. Input and output run decoupled through a
// two-entry job queue: an input byte is taken whenever the queue has room, and
// the output side sends one byte per cycle while m_tready allows it, so an item
// that yields k output bytes (up to 15, e.g. three replacements plus a \u00hh
// escape) holds the output side until all k are sent. Bytes of an open
// multi-byte sequence produce nothing until the sequence completes, breaks or
// the string ends.
module utf8_validate_string_escape (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // end_of_string
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // [0] last_of_run
  output logic       m_tlast    // string_done
);

  u8esc_pkg::u8esc_job_t fr_job;
  u8esc_pkg::u8esc_job_t head_job;
  logic fr_valid;
  logic q_full;
  logic q_not_empty;
  logic q_pop;
  logic accept;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // classify input bytes
  u8esc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_byte       (s_tdata),
    .end_of_string (s_tlast),
    .job           (fr_job),
    .job_valid     (fr_valid)
  );

  // job queue
  u8esc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (fr_valid),
    .wr_data   (fr_job),
    .rd_en     (q_pop),
    .rd_data   (head_job),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // emit output bytes
  u8esc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (head_job),
    .job_valid   (q_not_empty),
    .pop         (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_byte    (m_tdata),
    .last_of_run (m_tuser),
    .string_done (m_tlast)
  );

endmodule

[rtl/u8esc_check.sv]
`timescale 1ns / 1ps
module u8esc_check (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser,
  input logic       m_tlast
);

  // end of string is always the end of a run
  a_done_is_run_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("string end without run end");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // the queue is empty after reset, so input is taken
  a_reset_ready: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("input not ready after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast)))
    else $error("stalled output changed");

endmodule

bind utf8_validate_string_escape u8esc_check u_check (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
